// File: rtl/core/uv_sphere_mesh_generator_unit_defines.svh
// Assertion macros for the UV-sphere tessellation unit.
// Define NO_ASSERTIONS to compile them away.
`ifndef UV_SPHERE_MESH_GENERATOR_UNIT_DEFINES_SVH
`define UV_SPHERE_MESH_GENERATOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// property holds in every cycle out of reset
`define UVS_ASSERT_HOLDS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("uvs check failed");
// condition in this cycle implies property in the next one
`define UVS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("uvs sequence check failed");
`else
`define UVS_ASSERT_HOLDS(label, clk, rst_n, prop)
`define UVS_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

// File: rtl/core/uvs_pkg.sv
`timescale 1ns / 1ps

package uvs_pkg;

    // result kinds
    localparam logic [1:0] KIND_VERTEX    = 2'd0;
    localparam logic [1:0] KIND_TRIANGLE  = 2'd1;
    localparam logic [1:0] KIND_RANGE_ERR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_STACK_COUNT  = 2'd0;
    localparam logic [1:0] REG_SECTOR_COUNT = 2'd1;

    localparam logic [8:0] STACK_COUNT_RST  = 9'd16;
    localparam logic [8:0] SECTOR_COUNT_RST = 9'd32;
    localparam logic [8:0] STACK_COUNT_MIN  = 9'd2;
    localparam logic [8:0] SECTOR_COUNT_MIN = 9'd3;

    // Taylor coefficient magnitudes of sin(pi/2*z), Q30, alternating signs
    localparam logic [30:0] SINE_COEF [6] = '{
        31'd1686629713, 31'd693598668, 31'd85569306,
        31'd5026995,    31'd172272,    31'd3864
    };

    typedef struct packed {
        logic [8:0] stack_index;
        logic [8:0] sector_index;
    } t_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [16:0]        tex_s;
        logic [16:0]        tex_t;
        logic [16:0]        corner_first;
        logic [16:0]        corner_second;
        logic [16:0]        corner_third;
        logic               last;
    } t_result;

endpackage

// File: rtl/core/uv_sphere_mesh_generator_unit.sv
// UV-sphere tessellation unit: one grid point in, vertex plus up to two triangles (or a range error) out.
// Vertex result path: input, divider, fold, square, Horner, odd-factor, product, round and sequencer registers.
// Throughput: one point per cycle for single-result points; a point with more results
// holds the pipeline until its last result is out (at most 3), set by the single result port.
// Reset (synchronous, active low) empties the pipeline and loads 16 stacks, 32 sectors.
// The receiver cannot stall; busy is high only while a point is still emitting triangles.
`timescale 1ns / 1ps
`include "uv_sphere_mesh_generator_unit_defines.svh"

module uv_sphere_mesh_generator_unit #(
    parameter int MAX_STACKS      = 256,
    parameter int MAX_SECTORS     = 256,
    parameter int COORD_FRAC_BITS = 14
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    input  uvs_pkg::t_item  i_item,
    output logic            o_result_valid,
    output uvs_pkg::t_result o_result,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [1:0]      i_cfg_index,
    input  logic [8:0]      i_cfg_data
);
    import uvs_pkg::*;

    localparam int DIV_BITS   = 44;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = DIV_BITS / DIV_STEP;
    localparam int LANES      = 4;
    localparam int H_STAGES   = 5;
    localparam int XZ_SH      = 60 - COORD_FRAC_BITS;
    localparam int Y_SH       = 30 - COORD_FRAC_BITS;
    localparam logic [63:0] XZ_HALF   = (64'd1 << XZ_SH) >> 1;
    localparam logic [63:0] Y_HALF    = (64'd1 << Y_SH) >> 1;
    localparam logic [63:0] COORD_ONE = 64'd1 << COORD_FRAC_BITS;

    typedef struct packed {
        logic        err;
        logic        up;
        logic        lo;
        logic [8:0]  st;
        logic [8:0]  se;
        logic [16:0] v1;
        logic [16:0] v2;
        logic [16:0] tex_s;
        logic [16:0] tex_t;
    } t_meta;

    typedef struct packed {
        logic [8:0]          rem;
        logic [DIV_BITS-1:0] q;
    } t_div;

    typedef enum logic [1:0] {EM_VERT, EM_UP, EM_LOW, EM_ERR} t_em_state;

    // restoring long division, DIV_STEP quotient bits per stage
    function automatic t_div div_steps(input t_div cur, input logic [8:0] den);
        t_div       nx;
        logic [9:0] t;
        nx = cur;
        for (int s = 0; s < DIV_STEP; s++) begin
            t    = {nx.rem, nx.q[DIV_BITS-1]};
            nx.q = {nx.q[DIV_BITS-2:0], 1'b0};
            if (t >= {1'b0, den}) begin
                nx.rem  = 9'(t - {1'b0, den});
                nx.q[0] = 1'b1;
            end else begin
                nx.rem = t[8:0];
            end
        end
        return nx;
    endfunction

    // Q30 multiply with floor shift
    function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
        logic [61:0] p;
        p = 62'(a) * 62'(b);
        return 31'(p >> 30);
    endfunction

    // saturate a rounded magnitude at 1.0 and apply the sign
    function automatic logic [15:0] to_coord(input logic [63:0] v, input logic neg);
        logic [63:0] m;
        m = (v > COORD_ONE) ? COORD_ONE : v;
        if (neg) begin
            m = 64'd0 - m;
        end
        return m[15:0];
    endfunction

    // ---------------- configuration registers ----------------
    logic [8:0] r_stack_count;
    logic [8:0] r_sector_count;
    logic [8:0] w_stack_wr;
    logic [8:0] w_sector_wr;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_stack_wr = i_cfg_data;
        if (i_cfg_data < STACK_COUNT_MIN) begin
            w_stack_wr = STACK_COUNT_MIN;
        end else if (11'(i_cfg_data) > 11'(MAX_STACKS)) begin
            w_stack_wr = 9'(MAX_STACKS);
        end
        w_sector_wr = i_cfg_data;
        if (i_cfg_data < SECTOR_COUNT_MIN) begin
            w_sector_wr = SECTOR_COUNT_MIN;
        end else if (11'(i_cfg_data) > 11'(MAX_SECTORS)) begin
            w_sector_wr = 9'(MAX_SECTORS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_count  <= STACK_COUNT_RST;
            r_sector_count <= SECTOR_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_STACK_COUNT:  r_stack_count  <= w_stack_wr;
                REG_SECTOR_COUNT: r_sector_count <= w_sector_wr;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline registers ----------------
    logic w_adv;

    logic       r_a_valid;
    logic [8:0] r_a_i, r_a_j, r_a_st, r_a_se;

    logic  r_dv_valid [DIV_STAGES];
    t_meta r_dv_meta  [DIV_STAGES];
    t_div  r_dv       [DIV_STAGES][LANES];

    logic        r_p_valid;
    t_meta       r_p_meta;
    logic [30:0] r_p_z   [LANES];
    logic        r_p_neg [LANES];

    logic        r_z_valid;
    t_meta       r_z_meta;
    logic [30:0] r_z_z   [LANES];
    logic [30:0] r_z_z2  [LANES];
    logic        r_z_neg [LANES];

    logic        r_h_valid [H_STAGES];
    t_meta       r_h_meta  [H_STAGES];
    logic [30:0] r_h_z     [H_STAGES][LANES];
    logic [30:0] r_h_z2    [H_STAGES][LANES];
    logic [30:0] r_h_acc   [H_STAGES][LANES];
    logic        r_h_neg   [H_STAGES][LANES];

    logic        r_f_valid;
    t_meta       r_f_meta;
    logic [30:0] r_f_mag [LANES];
    logic        r_f_neg [LANES];

    logic        r_x_valid;
    t_meta       r_x_meta;
    logic [61:0] r_x_px, r_x_pz;
    logic [30:0] r_x_y;
    logic        r_x_xzero, r_x_yzero, r_x_zzero;
    logic        r_x_xneg, r_x_yneg, r_x_zneg;

    logic        r_r_valid;
    t_meta       r_r_meta;
    logic [15:0] r_r_x, r_r_y, r_r_z;

    // grid-point classification and vertex indices from the input stage
    t_meta       w_a_meta;
    logic [9:0]  w_se1;
    logic [19:0] w_v1_full;
    logic        w_cell;
    t_div        w_dv_in [LANES];

    always_comb begin
        w_se1     = {1'b0, r_a_se} + 10'd1;
        w_v1_full = 20'(r_a_i) * 20'(w_se1) + 20'(r_a_j);
        w_cell    = (r_a_i < r_a_st) && (r_a_j < r_a_se);
        w_a_meta       = '0;
        w_a_meta.err   = (r_a_i > r_a_st) || (r_a_j > r_a_se);
        w_a_meta.up    = w_cell && (r_a_i != 9'd0);
        w_a_meta.lo    = w_cell && ({1'b0, r_a_i} + 10'd1 < {1'b0, r_a_st});
        w_a_meta.st    = r_a_st;
        w_a_meta.se    = r_a_se;
        w_a_meta.v1    = w_v1_full[16:0];
        w_a_meta.v2    = 17'(w_v1_full + 20'(w_se1));
        // lanes: phase of a, phase of b, tex_t, tex_s
        w_dv_in[0].rem = '0;
        w_dv_in[0].q   = (44'(r_a_i) << 31) + 44'(r_a_st >> 1);
        w_dv_in[1].rem = '0;
        w_dv_in[1].q   = (44'(r_a_j) << 32) + 44'(r_a_se >> 1);
        w_dv_in[2].rem = '0;
        w_dv_in[2].q   = (44'(r_a_i) << 16) + 44'(r_a_st >> 1);
        w_dv_in[3].rem = '0;
        w_dv_in[3].q   = (44'(r_a_j) << 16) + 44'(r_a_se >> 1);
    end

    // phase folding at the divider output
    logic [31:0] w_phase [LANES];
    t_meta       w_dv_out_meta;

    always_comb begin
        w_phase[0] = r_dv[DIV_STAGES-1][0].q[31:0];
        w_phase[1] = r_dv[DIV_STAGES-1][0].q[31:0] + 32'h4000_0000;
        w_phase[2] = r_dv[DIV_STAGES-1][1].q[31:0];
        w_phase[3] = r_dv[DIV_STAGES-1][1].q[31:0] + 32'h4000_0000;
        w_dv_out_meta       = r_dv_meta[DIV_STAGES-1];
        w_dv_out_meta.tex_t = r_dv[DIV_STAGES-1][2].q[16:0];
        w_dv_out_meta.tex_s = r_dv[DIV_STAGES-1][3].q[16:0];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            for (int d = 0; d < DIV_STAGES; d++) begin
                r_dv_valid[d] <= 1'b0;
            end
            r_p_valid <= 1'b0;
            r_z_valid <= 1'b0;
            for (int h = 0; h < H_STAGES; h++) begin
                r_h_valid[h] <= 1'b0;
            end
            r_f_valid <= 1'b0;
            r_x_valid <= 1'b0;
            r_r_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid     <= i_start;
            r_dv_valid[0] <= r_a_valid;
            for (int d = 1; d < DIV_STAGES; d++) begin
                r_dv_valid[d] <= r_dv_valid[d-1];
            end
            r_p_valid    <= r_dv_valid[DIV_STAGES-1];
            r_z_valid    <= r_p_valid;
            r_h_valid[0] <= r_z_valid;
            for (int h = 1; h < H_STAGES; h++) begin
                r_h_valid[h] <= r_h_valid[h-1];
            end
            r_f_valid <= r_h_valid[H_STAGES-1];
            r_x_valid <= r_f_valid;
            r_r_valid <= r_x_valid;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // input capture
            r_a_i  <= i_item.stack_index;
            r_a_j  <= i_item.sector_index;
            r_a_st <= r_stack_count;
            r_a_se <= r_sector_count;

            // divider stages
            r_dv_meta[0] <= w_a_meta;
            for (int l = 0; l < LANES; l++) begin
                r_dv[0][l] <= div_steps(w_dv_in[l], l[0] ? r_a_se : r_a_st);
            end
            for (int d = 1; d < DIV_STAGES; d++) begin
                r_dv_meta[d] <= r_dv_meta[d-1];
                for (int l = 0; l < LANES; l++) begin
                    r_dv[d][l] <= div_steps(r_dv[d-1][l],
                                            l[0] ? r_dv_meta[d-1].se : r_dv_meta[d-1].st);
                end
            end

            // fold to a quarter wave
            r_p_meta <= w_dv_out_meta;
            for (int l = 0; l < LANES; l++) begin
                r_p_z[l]   <= w_phase[l][30] ? (31'h4000_0000 - {1'b0, w_phase[l][29:0]})
                                             : {1'b0, w_phase[l][29:0]};
                r_p_neg[l] <= w_phase[l][31];
            end

            // z squared
            r_z_meta <= r_p_meta;
            for (int l = 0; l < LANES; l++) begin
                r_z_z[l]   <= r_p_z[l];
                r_z_z2[l]  <= mul_q30(r_p_z[l], r_p_z[l]);
                r_z_neg[l] <= r_p_neg[l];
            end

            // Horner steps, highest coefficient first
            r_h_meta[0] <= r_z_meta;
            for (int l = 0; l < LANES; l++) begin
                r_h_z[0][l]   <= r_z_z[l];
                r_h_z2[0][l]  <= r_z_z2[l];
                r_h_neg[0][l] <= r_z_neg[l];
                r_h_acc[0][l] <= SINE_COEF[4] - mul_q30(r_z_z2[l], SINE_COEF[5]);
            end
            for (int h = 1; h < H_STAGES; h++) begin
                r_h_meta[h] <= r_h_meta[h-1];
                for (int l = 0; l < LANES; l++) begin
                    r_h_z[h][l]   <= r_h_z[h-1][l];
                    r_h_z2[h][l]  <= r_h_z2[h-1][l];
                    r_h_neg[h][l] <= r_h_neg[h-1][l];
                    r_h_acc[h][l] <= SINE_COEF[4-h]
                                     - mul_q30(r_h_z2[h-1][l], r_h_acc[h-1][l]);
                end
            end

            // final odd factor
            r_f_meta <= r_h_meta[H_STAGES-1];
            for (int l = 0; l < LANES; l++) begin
                r_f_mag[l] <= mul_q30(r_h_z[H_STAGES-1][l], r_h_acc[H_STAGES-1][l]);
                r_f_neg[l] <= r_h_neg[H_STAGES-1][l];
            end

            // x = sin(a)*sin(b), z = sin(a)*cos(b), y = cos(a)
            r_x_meta  <= r_f_meta;
            r_x_px    <= 62'(r_f_mag[0]) * 62'(r_f_mag[2]);
            r_x_pz    <= 62'(r_f_mag[0]) * 62'(r_f_mag[3]);
            r_x_y     <= r_f_mag[1];
            r_x_xzero <= (r_f_mag[0] == '0) || (r_f_mag[2] == '0);
            r_x_zzero <= (r_f_mag[0] == '0) || (r_f_mag[3] == '0);
            r_x_yzero <= (r_f_mag[1] == '0);
            r_x_xneg  <= r_f_neg[0] ^ r_f_neg[2];
            r_x_zneg  <= r_f_neg[0] ^ r_f_neg[3];
            r_x_yneg  <= r_f_neg[1];

            // round half up on magnitude, saturate, sign
            r_r_meta <= r_x_meta;
            r_r_x <= r_x_xzero ? 16'd0
                     : to_coord((64'(r_x_px) + XZ_HALF) >> XZ_SH, r_x_xneg);
            r_r_z <= r_x_zzero ? 16'd0
                     : to_coord((64'(r_x_pz) + XZ_HALF) >> XZ_SH, r_x_zneg);
            r_r_y <= r_x_yzero ? 16'd0
                     : to_coord((64'(r_x_y) + Y_HALF) >> Y_SH, r_x_yneg);
        end
    end

    // ---------------- result sequencer ----------------
    t_em_state   r_em_state;
    logic        r_em_valid;
    logic        r_em_up_pend;
    logic        r_em_lo_pend;
    t_meta       r_em_meta;
    logic [15:0] r_em_x, r_em_y, r_em_z;
    logic        w_em_last;

    assign w_em_last = !(r_em_up_pend || r_em_lo_pend);
    assign w_adv     = !(r_em_valid && !w_em_last);
    assign o_busy    = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_valid   <= 1'b0;
            r_em_state   <= EM_VERT;
            r_em_up_pend <= 1'b0;
            r_em_lo_pend <= 1'b0;
        end else if (w_adv) begin
            r_em_valid   <= r_r_valid;
            r_em_state   <= r_r_meta.err ? EM_ERR : EM_VERT;
            r_em_up_pend <= r_r_valid && !r_r_meta.err && r_r_meta.up;
            r_em_lo_pend <= r_r_valid && !r_r_meta.err && r_r_meta.lo;
            r_em_meta    <= r_r_meta;
            r_em_x       <= r_r_x;
            r_em_y       <= r_r_y;
            r_em_z       <= r_r_z;
        end else if (r_em_up_pend) begin
            r_em_state   <= EM_UP;
            r_em_up_pend <= 1'b0;
        end else begin
            r_em_state   <= EM_LOW;
            r_em_lo_pend <= 1'b0;
        end
    end

    // result fields for the current transfer
    always_comb begin
        o_result      = '0;
        o_result.last = w_em_last;
        unique case (r_em_state)
            EM_VERT: begin
                o_result.kind  = KIND_VERTEX;
                o_result.pos_x = r_em_x;
                o_result.pos_y = r_em_y;
                o_result.pos_z = r_em_z;
                o_result.tex_s = r_em_meta.tex_s;
                o_result.tex_t = r_em_meta.tex_t;
            end
            EM_UP: begin
                o_result.kind          = KIND_TRIANGLE;
                o_result.corner_first  = r_em_meta.v1;
                o_result.corner_second = r_em_meta.v2;
                o_result.corner_third  = r_em_meta.v1 + 17'd1;
            end
            EM_LOW: begin
                o_result.kind          = KIND_TRIANGLE;
                o_result.corner_first  = r_em_meta.v1 + 17'd1;
                o_result.corner_second = r_em_meta.v2;
                o_result.corner_third  = r_em_meta.v2 + 17'd1;
            end
            default: begin
                o_result.kind = KIND_RANGE_ERR;
            end
        endcase
    end

    assign o_result_valid = r_em_valid;

    // ---------------- checks ----------------
    `UVS_ASSERT_HOLDS(a_busy_only_emitting, i_clk, i_rst_n, !o_busy || o_result_valid)
    `UVS_ASSERT_HOLDS(a_err_single, i_clk, i_rst_n, !(o_result_valid && o_result.kind == KIND_RANGE_ERR) || o_result.last)
    `UVS_ASSERT_NEXT(a_tri_follows, i_clk, i_rst_n, o_result_valid && !o_result.last, o_result_valid && o_result.kind == KIND_TRIANGLE)
    `UVS_ASSERT_HOLDS(a_cfg_range, i_clk, i_rst_n, r_stack_count >= STACK_COUNT_MIN && r_sector_count >= SECTOR_COUNT_MIN)

endmodule
